// ===== rtl/core/tcc_pkg.sv =====
// Package for the temperature channel conditioner: payload structs, command and
// kind codes, register indices and fixed field widths. No dependencies.
package tcc_pkg;

  localparam int TEMP_W = 12;
  localparam int CH_W   = 3;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_PERIOD = 1'b1;

  localparam logic [1:0] REG_PERIOD_ROUNDS = 2'd0;
  localparam logic [1:0] REG_LOW_LIMIT     = 2'd1;
  localparam logic [1:0] REG_HIGH_LIMIT    = 2'd2;

  typedef struct packed {
    logic                     command;
    logic [CH_W-1:0]          channel;
    logic signed [TEMP_W-1:0] temperature;
    logic                     round_end;
  } in_item_t;

  typedef struct packed {
    logic                     kind;
    logic [CH_W-1:0]          out_channel;
    logic signed [TEMP_W-1:0] mean_value;
    logic                     sample_valid;
    logic                     mean_valid;
    logic [7:0]               error_total;
    logic                     last_result;
  } out_item_t;

endpackage

// ===== rtl/core/tcc_divider.sv =====
// Bit-serial signed divider: one quotient bit per cycle, truncation toward zero.
// Depends on tcc_pkg for the temperature width.
module tcc_divider #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [NUM_W-1:0]         numer,
  input  logic [DEN_W-1:0]                denom,
  output logic                            done,
  output logic signed [tcc_pkg::TEMP_W-1:0] quot
);
  import tcc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [NUM_W-1:0] dividend;
  logic [DEN_W:0]   remainder;
  logic [DEN_W-1:0] divisor;
  logic             negative;
  logic [DEN_W:0]   trial;
  logic [NUM_W-1:0] mag;

  assign mag   = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
  assign trial = {remainder[DEN_W-1:0], dividend[NUM_W-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (count == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
    if (start) begin
      dividend  <= mag;
      remainder <= '0;
      divisor   <= denom;
      negative  <= numer[NUM_W-1];
    end else if (busy) begin
      // Shift one numerator bit in; the quotient fills in behind it.
      if (!trial[DEN_W]) begin
        remainder <= trial;
        dividend  <= {dividend[NUM_W-2:0], 1'b1};
      end else begin
        remainder <= {remainder[DEN_W-1:0], dividend[NUM_W-1]};
        dividend  <= {dividend[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot = negative ? TEMP_W'(-dividend) : TEMP_W'(dividend);
endmodule

// ===== rtl/core/temperature_channel_conditioner_unit.sv =====
// Top level of the temperature channel conditioner.
// Depends on tcc_pkg and tcc_divider.
//
// One item is processed at a time. A sample passes through a read step, an
// update step, a divider start, a bit-serial division for the window mean, a
// capture of the quotient and a hand-on of the result before the input is
// ready again. When a period closes, each channel's period report adds a start
// request, the divider start, a division, capture and hand-on. A preload sweeps
// the channel window one entry per cycle and then hands its result on. Each
// result waits in a single holding slot in front of the output register; a new
// item is taken only once that slot is empty, so a stalled output also holds
// off the next item. Input channels at or above CHANNELS are taken without a
// result. After reset the window memory is cleared by a pass over all
// CHANNELS * WINDOW_DEPTH entries, during which no input item is taken
// (configuration writes still are).
module temperature_channel_conditioner_unit #(
  parameter int CHANNELS     = 2,
  parameter int WINDOW_DEPTH = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tcc_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import tcc_pkg::*;

  localparam int CHI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = $clog2(WINDOW_DEPTH);
  localparam int MEM_D  = CHANNELS * WINDOW_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int WSUM_W = TEMP_W + $clog2(WINDOW_DEPTH) + 1;
  localparam int PSUM_W = 20;
  localparam int DIV_W  = (WSUM_W > PSUM_W) ? WSUM_W : PSUM_W;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_READ    = 4'd2;
  localparam logic [3:0] S_UPDATE  = 4'd3;
  localparam logic [3:0] S_WDIV    = 4'd4;
  localparam logic [3:0] S_PSTART  = 4'd5;
  localparam logic [3:0] S_PDIV    = 4'd6;
  localparam logic [3:0] S_PRELOAD = 4'd7;
  localparam logic [3:0] S_PUSH    = 4'd8;

  logic [3:0] state;

  // Configuration registers; the port is always ready.
  logic [7:0]               period_rounds;
  logic signed [TEMP_W-1:0] low_limit;
  logic signed [TEMP_W-1:0] high_limit;
  assign cfg_ready = 1'b1;

  // Per-channel state, in flip-flops.
  logic signed [TEMP_W-1:0] last_good    [CHANNELS];
  logic [7:0]               error_tally  [CHANNELS];
  logic signed [PSUM_W-1:0] period_sum   [CHANNELS];
  logic [7:0]               period_count [CHANNELS];
  logic signed [WSUM_W-1:0] window_sum   [CHANNELS];
  logic [POS_W-1:0]         window_pos   [CHANNELS];
  logic [7:0]               round_tally;

  // Window memory, one read and one write port.
  logic signed [TEMP_W-1:0] window_mem [MEM_D];
  logic signed [TEMP_W-1:0] mem_rdata;
  logic [ADDR_W-1:0]        mem_raddr;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [TEMP_W-1:0] mem_wdata;
  logic                     mem_we;

  // Item being processed.
  in_item_t                 item;
  logic [CHI_W-1:0]         ch;
  logic                     ok;
  logic                     period_due;
  logic [CHI_W-1:0]         rep_ch;
  logic [POS_W-1:0]         sweep;
  logic [ADDR_W-1:0]        clear_addr;

  // Pending result waiting for the output register.
  out_item_t pending;
  logic      pending_valid;

  // Divider.
  logic                     div_start;
  logic signed [DIV_W-1:0]  div_num;
  logic [7:0]               div_den;
  logic                     div_done;
  logic signed [TEMP_W-1:0] div_quot;

  tcc_divider #(.NUM_W(DIV_W), .DEN_W(8)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_num),
    .denom (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  logic in_fire, out_free;
  // A new item waits until the previous result has left the holding slot.
  assign in_ready = (state == S_IDLE) && !pending_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  logic [ADDR_W-1:0] base;
  assign base = ADDR_W'(ch) * ADDR_W'(WINDOW_DEPTH);

  logic in_range;
  assign in_range = (in_data.temperature > low_limit) && (in_data.temperature < high_limit);

  logic signed [TEMP_W-1:0] value_next;
  assign value_next = ok ? item.temperature : last_good[ch];

  logic [7:0] round_next;
  assign round_next = (round_tally == 8'd255) ? round_tally : round_tally + 8'd1;

  always_ff @(posedge clk) begin
    if (mem_we) window_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= window_mem[mem_raddr];
  end

  always_comb begin
    mem_raddr = base + ADDR_W'(window_pos[ch]);
    mem_we    = 1'b0;
    mem_waddr = base + ADDR_W'(window_pos[ch]);
    mem_wdata = value_next;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else if (state == S_UPDATE) begin
      mem_we = 1'b1;
    end else if (state == S_PRELOAD) begin
      mem_we = 1'b1;
      mem_waddr = base + ADDR_W'(sweep);
      mem_wdata = last_good[ch];
    end
  end

  // Output register: loads a pending result whenever it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pending_valid;
      out_data  <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clear_addr    <= '0;
      pending_valid <= 1'b0;
      div_start     <= 1'b0;
      period_rounds <= 8'd12;
      low_limit     <= -12'sd640;
      high_limit    <= 12'sd960;
      round_tally   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_good[c]    <= TEMP_W'((c - 35) * 16);
        error_tally[c]  <= '0;
        period_sum[c]   <= '0;
        period_count[c] <= '0;
        window_sum[c]   <= '0;
        window_pos[c]   <= '0;
      end
    end else begin
      div_start <= (state == S_UPDATE) ||
                   ((state == S_PSTART) && (!pending_valid || out_free));
      // The slot fills in S_PUSH and empties when the output register takes it.
      pending_valid <= ((state == S_PUSH) && (!pending_valid || out_free)) ||
                       (pending_valid && !out_free);
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PERIOD_ROUNDS: period_rounds <= cfg_data[7:0];
          REG_LOW_LIMIT:     low_limit     <= cfg_data;
          REG_HIGH_LIMIT:    high_limit    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == ADDR_W'(MEM_D - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire && (32'(in_data.channel) < CHANNELS)) begin
            item  <= in_data;
            ch    <= CHI_W'(in_data.channel);
            ok    <= in_range;
            sweep <= '0;
            state <= (in_data.command == CMD_PRELOAD) ? S_PRELOAD : S_READ;
          end
        end
        S_READ: state <= S_UPDATE;
        S_UPDATE: begin
          if (ok) last_good[ch] <= item.temperature;
          else if (error_tally[ch] != 8'd255) error_tally[ch] <= error_tally[ch] + 8'd1;
          if (period_count[ch] != 8'd255) begin
            period_sum[ch]   <= period_sum[ch] + PSUM_W'(value_next);
            period_count[ch] <= period_count[ch] + 8'd1;
          end
          window_sum[ch] <= window_sum[ch] - WSUM_W'(mem_rdata) + WSUM_W'(value_next);
          window_pos[ch] <= (window_pos[ch] == POS_W'(WINDOW_DEPTH - 1)) ? '0
                          : window_pos[ch] + 1'b1;
          div_num   <= DIV_W'(window_sum[ch] - WSUM_W'(mem_rdata) + WSUM_W'(value_next));
          div_den   <= 8'(WINDOW_DEPTH);
          period_due <= item.round_end && (round_next >= period_rounds);
          if (item.round_end) round_tally <= round_next;
          state <= S_WDIV;
        end
        S_WDIV: begin
          if (div_done) begin
            pending <= '{kind: KIND_WINDOW, out_channel: item.channel,
                         mean_value: div_quot, sample_valid: ok, mean_valid: 1'b0,
                         error_total: 8'd0, last_result: !period_due};
            state   <= S_PUSH;
            rep_ch  <= '0;
          end
        end
        S_PUSH: begin
          if (!pending_valid || out_free) begin
            state <= pending.last_result ? S_IDLE : S_PSTART;
          end
        end
        S_PSTART: begin
          if (!pending_valid || out_free) begin
            div_num   <= DIV_W'(period_sum[rep_ch]);
            div_den   <= period_count[rep_ch];
            state     <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            pending <= '{kind: KIND_PERIOD, out_channel: CH_W'(rep_ch),
                         mean_value: (period_count[rep_ch] == 0) ? '0 : div_quot,
                         sample_valid: 1'b0,
                         mean_valid: (period_count[rep_ch] != 0),
                         error_total: error_tally[rep_ch],
                         last_result: (32'(rep_ch) == CHANNELS - 1)};
            period_sum[rep_ch]   <= '0;
            period_count[rep_ch] <= '0;
            error_tally[rep_ch]  <= '0;
            rep_ch <= rep_ch + 1'b1;
            if (32'(rep_ch) == CHANNELS - 1) round_tally <= '0;
            state <= S_PUSH;
          end
        end
        S_PRELOAD: begin
          sweep <= sweep + 1'b1;
          if (sweep == POS_W'(WINDOW_DEPTH - 1)) begin
            window_sum[ch] <= WSUM_W'(last_good[ch]) * WSUM_W'(WINDOW_DEPTH);
            window_pos[ch] <= '0;
            period_due <= 1'b0;
            pending <= '{kind: KIND_WINDOW, out_channel: item.channel,
                         mean_value: last_good[ch], sample_valid: 1'b0,
                         mean_valid: 1'b0, error_total: 8'd0, last_result: 1'b1};
            state <= S_PUSH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted item for an existing channel starts processing at once.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && (32'(in_data.channel) < CHANNELS)) |=> !(state == S_IDLE))
    else $error("accepted item did not start");
  // Nothing is accepted during the clearing pass.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready) else $error("input taken while clearing");
  // A held result stays put until transferred.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");
endmodule
